// ===== hw/rtl/rau_pkg.sv =====
// Shared types, codes and constants of the rational arithmetic unit.
package rau_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int QUEUE_DEPTH   = 2;

   // Operation codes
   localparam logic [2:0] MODE_ADD   = 3'd0;
   localparam logic [2:0] MODE_SUB   = 3'd1;
   localparam logic [2:0] MODE_MUL   = 3'd2;
   localparam logic [2:0] MODE_DIV   = 3'd3;
   localparam logic [2:0] MODE_CMP   = 3'd4;
   localparam logic [2:0] MODE_NEG   = 3'd5;
   localparam logic [2:0] MODE_SPLIT = 3'd6;

   // Status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DIVZ = 2'd1;
   localparam logic [1:0] STAT_OVF  = 2'd2;

   // Request class decided by the front end
   typedef enum logic [1:0] {
      CLS_RUN = 2'd0,
      CLS_ERR = 2'd1,
      CLS_NOP = 2'd2
   } rau_class_type;

   typedef struct packed {
      rau_class_type      cls;
      logic [2:0]         mode;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } rau_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } rau_qstat_type;

endpackage

// ===== hw/rtl/rau_front.sv =====
// Front end: request handshake and classification of each request.
module rau_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_mode,
   input  logic signed [31:0]    req_a_num,
   input  logic [30:0]           req_a_den,
   input  logic signed [31:0]    req_b_num,
   input  logic [30:0]           req_b_den,
   input  rau_pkg::rau_qstat_type q_stat,
   output logic                  q_push,
   output rau_pkg::rau_item_type q_item
);
   import rau_pkg::*;

   logic den_zero;
   logic div_zero;

   // Stall while the queue is full
   assign req_stall = q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   // Classify: unused mode first, then zero denominators and zero divisors
   assign den_zero = (req_a_den == 31'd0) || (req_b_den == 31'd0);
   assign div_zero = (req_mode == MODE_DIV) && (req_b_num == 32'sd0);

   always_comb begin
      q_item.mode  = req_mode;
      q_item.a_num = req_a_num;
      q_item.a_den = req_a_den;
      q_item.b_num = req_b_num;
      q_item.b_den = req_b_den;
      if (req_mode > MODE_SPLIT) begin
         q_item.cls = CLS_NOP;
      end else if (den_zero || div_zero) begin
         q_item.cls = CLS_ERR;
      end else begin
         q_item.cls = CLS_RUN;
      end
   end

endmodule

// ===== hw/rtl/rau_queue.sv =====
// Short request queue between the front end and the back end.
module rau_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_push,
   input  rau_pkg::rau_item_type  q_item,
   input  logic                   q_pop,
   output rau_pkg::rau_item_type  q_head,
   output rau_pkg::rau_qstat_type q_stat
);
   import rau_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   rau_item_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign q_stat.empty = (cnt_ff == CNT_BITS'(0));
   assign q_stat.full  = (cnt_ff == CNT_BITS'(QUEUE_DEPTH));
   assign q_head       = mem_ff[rd_ptr_ff];
   assign do_push      = q_push && !q_stat.full;
   assign do_pop       = q_pop && !q_stat.empty;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_item;
      end
   end

endmodule

// ===== hw/rtl/rau_back.sv =====
// Back end: products, sign handling, binary GCD, exact division and range check.
module rau_back #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rau_pkg::rau_qstat_type q_stat,
   input  rau_pkg::rau_item_type  q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_res_num,
   output logic [30:0]            rsp_res_den,
   output logic signed [31:0]     rsp_whole_part,
   output logic [1:0]             rsp_status,
   output logic                   rsp_cmp_less,
   output logic                   rsp_cmp_equal,
   output logic                   rsp_cmp_greater
);
   import rau_pkg::*;

   localparam logic [63:0] LIM = 64'd1 << (WORD_BITS - 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_COMB = 7'b0000100,
      ST_SIGN = 7'b0001000,
      ST_GCD  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   rau_item_type       item_ff, item_in;
   logic [1:0]         step_ff, step_in;
   logic signed [63:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [63:0] n_ff, n_in, d_ff, d_in;
   logic               neg_ff, neg_in;
   logic [63:0]        mn_ff, mn_in, md_ff, md_in;
   logic [63:0]        x_ff, x_in, y_ff, y_in;
   logic [5:0]         k_ff, k_in;
   logic [63:0]        dvs_ff, dvs_in;
   logic [63:0]        rem0_ff, rem0_in, quo0_ff, quo0_in;
   logic [63:0]        rem1_ff, rem1_in, quo1_ff, quo1_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               split_ff, split_in;
   logic [31:0]        fin_num_ff, fin_num_in;
   logic [30:0]        fin_den_ff, fin_den_in;
   logic [31:0]        fin_whole_ff, fin_whole_in;
   logic [1:0]         fin_status_ff, fin_status_in;
   logic               fin_lt_ff, fin_lt_in, fin_eq_ff, fin_eq_in, fin_gt_ff, fin_gt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_num_ff, rsp_num_in;
   logic [30:0]        rsp_den_ff, rsp_den_in;
   logic [31:0]        rsp_whole_ff, rsp_whole_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_lt_ff, rsp_lt_in, rsp_eq_ff, rsp_eq_in, rsp_gt_ff, rsp_gt_in;

   logic signed [32:0] an33, ad33, bn33, bd33, mx, my;
   logic signed [65:0] prod;
   logic signed [63:0] sum;
   logic [63:0]        head_an64, head_mag;
   logic [63:0]        gsrc, gval;
   logic [64:0]        sh0, sh1;
   logic               ge0, ge1;
   logic [63:0]        rem0_step, quo0_step, rem1_step, quo1_step;
   logic [63:0]        negq0;
   logic               split_fits;
   logic               out_free;

   // Select multiplier operands for the current product
   assign an33 = {item_ff.a_num[31], item_ff.a_num};
   assign ad33 = {2'b00, item_ff.a_den};
   assign bn33 = {item_ff.b_num[31], item_ff.b_num};
   assign bd33 = {2'b00, item_ff.b_den};

   always_comb begin
      case (step_ff)
         2'd0: begin
            mx = an33;
            if (item_ff.mode == MODE_MUL) begin
               my = bn33;
            end else if (item_ff.mode == MODE_NEG) begin
               my = -33'sd1;
            end else begin
               my = bd33;
            end
         end
         2'd1: begin
            mx = bn33;
            if (item_ff.mode == MODE_ADD || item_ff.mode == MODE_SUB ||
                item_ff.mode == MODE_CMP) begin
               my = ad33;
            end else begin
               my = 33'sd0;
            end
         end
         default: begin
            mx = ad33;
            if (item_ff.mode == MODE_DIV) begin
               my = bn33;
            end else if (item_ff.mode == MODE_NEG) begin
               my = 33'sd1;
            end else begin
               my = bd33;
            end
         end
      endcase
   end

   assign prod = mx * my;
   assign sum  = (item_ff.mode == MODE_SUB) ? (p0_ff - p1_ff) : (p0_ff + p1_ff);

   // Magnitude of the first numerator for the split path
   assign head_an64 = {{32{q_head.a_num[31]}}, q_head.a_num};
   assign head_mag  = q_head.a_num[31] ? (64'd0 - head_an64) : head_an64;

   // GCD result once one operand reaches zero
   assign gsrc = (y_ff == 64'd0) ? x_ff : y_ff;
   assign gval = (gsrc == 64'd0) ? 64'd1 : (gsrc << k_ff);

   // One restoring division step on each lane
   assign sh0       = {rem0_ff, quo0_ff[63]};
   assign sh1       = {rem1_ff, quo1_ff[63]};
   assign ge0       = sh0 >= {1'b0, dvs_ff};
   assign ge1       = sh1 >= {1'b0, dvs_ff};
   assign rem0_step = ge0 ? 64'(sh0 - {1'b0, dvs_ff}) : sh0[63:0];
   assign rem1_step = ge1 ? 64'(sh1 - {1'b0, dvs_ff}) : sh1[63:0];
   assign quo0_step = {quo0_ff[62:0], ge0};
   assign quo1_step = {quo1_ff[62:0], ge1};

   assign negq0      = 64'd0 - quo0_step;
   assign split_fits = item_ff.a_num[31] ? (quo0_step <= LIM) : (quo0_step <= LIM - 64'd1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      step_in       = step_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      neg_in        = neg_ff;
      mn_in         = mn_ff;
      md_in         = md_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      k_in          = k_ff;
      dvs_in        = dvs_ff;
      rem0_in       = rem0_ff;
      quo0_in       = quo0_ff;
      rem1_in       = rem1_ff;
      quo1_in       = quo1_ff;
      cnt_in        = cnt_ff;
      split_in      = split_ff;
      fin_num_in    = fin_num_ff;
      fin_den_in    = fin_den_ff;
      fin_whole_in  = fin_whole_ff;
      fin_status_in = fin_status_ff;
      fin_lt_in     = fin_lt_ff;
      fin_eq_in     = fin_eq_ff;
      fin_gt_in     = fin_gt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_whole_in  = rsp_whole_ff;
      rsp_status_in = rsp_status_ff;
      rsp_lt_in     = rsp_lt_ff;
      rsp_eq_in     = rsp_eq_ff;
      rsp_gt_in     = rsp_gt_ff;
      q_pop         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Take the next request and preset a neutral result
            if (!q_stat.empty) begin
               q_pop         = 1'b1;
               item_in       = q_head;
               step_in       = 2'd0;
               fin_num_in    = 32'd0;
               fin_den_in    = 31'd1;
               fin_whole_in  = 32'd0;
               fin_status_in = STAT_OK;
               fin_lt_in     = 1'b0;
               fin_eq_in     = 1'b0;
               fin_gt_in     = 1'b0;
               case (q_head.cls)
                  CLS_ERR: begin
                     fin_status_in = STAT_DIVZ;
                     state_in      = ST_DONE;
                  end
                  CLS_NOP: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     if (q_head.mode == MODE_SPLIT) begin
                        rem0_in  = 64'd0;
                        quo0_in  = head_mag;
                        rem1_in  = 64'd0;
                        quo1_in  = 64'd0;
                        dvs_in   = {33'd0, q_head.a_den};
                        cnt_in   = 6'd0;
                        split_in = 1'b1;
                        state_in = ST_DIV;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
               endcase
            end
         end
         ST_MUL: begin
            // Form one cross product per cycle
            case (step_ff)
               2'd0:    p0_in = prod[63:0];
               2'd1:    p1_in = prod[63:0];
               default: p2_in = prod[63:0];
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = ST_COMB;
            end
         end
         ST_COMB: begin
            // Combine products, or finish a compare
            if (item_ff.mode == MODE_CMP) begin
               fin_lt_in = p0_ff < p1_ff;
               fin_eq_in = p0_ff == p1_ff;
               fin_gt_in = p0_ff > p1_ff;
               state_in  = ST_DONE;
            end else begin
               n_in     = sum;
               d_in     = p2_ff;
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            // Move the sign to the numerator and take magnitudes
            neg_in   = n_ff[63] ^ d_ff[63];
            mn_in    = n_ff[63] ? (64'd0 - 64'(n_ff)) : 64'(n_ff);
            md_in    = d_ff[63] ? (64'd0 - 64'(d_ff)) : 64'(d_ff);
            x_in     = mn_in;
            y_in     = md_in;
            k_in     = 6'd0;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            // Binary GCD, one step per cycle
            if (x_ff == 64'd0 || y_ff == 64'd0) begin
               dvs_in   = gval;
               rem0_in  = 64'd0;
               quo0_in  = mn_ff;
               rem1_in  = 64'd0;
               quo1_in  = md_ff;
               cnt_in   = 6'd0;
               split_in = 1'b0;
               state_in = ST_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         ST_DIV: begin
            // Shift one quotient bit into each lane
            rem0_in = rem0_step;
            quo0_in = quo0_step;
            rem1_in = rem1_step;
            quo1_in = quo1_step;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (split_ff) begin
                  if (!split_fits) begin
                     fin_status_in = STAT_OVF;
                     state_in      = ST_DONE;
                  end else begin
                     fin_whole_in = item_ff.a_num[31] ? negq0[31:0] : quo0_step[31:0];
                     neg_in       = item_ff.a_num[31];
                     mn_in        = rem0_step;
                     md_in        = {33'd0, item_ff.a_den};
                     x_in         = rem0_step;
                     y_in         = {33'd0, item_ff.a_den};
                     k_in         = 6'd0;
                     state_in     = ST_GCD;
                  end
               end else begin
                  // Range check of the reduced pair
                  if ((quo1_step > LIM - 64'd1) ||
                      (neg_ff && quo0_step != 64'd0 && quo0_step > LIM) ||
                      ((!neg_ff || quo0_step == 64'd0) && quo0_step > LIM - 64'd1)) begin
                     fin_num_in    = 32'd0;
                     fin_den_in    = 31'd1;
                     fin_whole_in  = 32'd0;
                     fin_status_in = STAT_OVF;
                  end else begin
                     fin_num_in = neg_ff ? negq0[31:0] : quo0_step[31:0];
                     fin_den_in = quo1_step[30:0];
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = fin_num_ff;
               rsp_den_in    = fin_den_ff;
               rsp_whole_in  = fin_whole_ff;
               rsp_status_in = fin_status_ff;
               rsp_lt_in     = fin_lt_ff;
               rsp_eq_in     = fin_eq_ff;
               rsp_gt_in     = fin_gt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      step_ff       <= step_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      n_ff          <= n_in;
      d_ff          <= d_in;
      neg_ff        <= neg_in;
      mn_ff         <= mn_in;
      md_ff         <= md_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      k_ff          <= k_in;
      dvs_ff        <= dvs_in;
      rem0_ff       <= rem0_in;
      quo0_ff       <= quo0_in;
      rem1_ff       <= rem1_in;
      quo1_ff       <= quo1_in;
      cnt_ff        <= cnt_in;
      split_ff      <= split_in;
      fin_num_ff    <= fin_num_in;
      fin_den_ff    <= fin_den_in;
      fin_whole_ff  <= fin_whole_in;
      fin_status_ff <= fin_status_in;
      fin_lt_ff     <= fin_lt_in;
      fin_eq_ff     <= fin_eq_in;
      fin_gt_ff     <= fin_gt_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_whole_ff  <= rsp_whole_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lt_ff     <= rsp_lt_in;
      rsp_eq_ff     <= rsp_eq_in;
      rsp_gt_ff     <= rsp_gt_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_num     = rsp_num_ff;
   assign rsp_res_den     = rsp_den_ff;
   assign rsp_whole_part  = rsp_whole_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_cmp_less    = rsp_lt_ff;
   assign rsp_cmp_equal   = rsp_eq_ff;
   assign rsp_cmp_greater = rsp_gt_ff;

endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: front end, request queue, back end.
// Error and unused-mode requests go straight to the result; compare ends after the
// products; others add sign, GCD and division; split: division, GCD, division.
// Throughput: one request at a time in the back end, set by the binary GCD
// loop and the one-bit-per-cycle divider; two requests queue ahead of it.
// Reset: synchronous, active high; empties the queue and the output register.
module rational_arith_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_a_num,
   input  logic [30:0]        req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic [30:0]        req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic signed [31:0] rsp_whole_part,
   output logic [1:0]         rsp_status,
   output logic               rsp_cmp_less,
   output logic               rsp_cmp_equal,
   output logic               rsp_cmp_greater
);
   import rau_pkg::*;

   rau_qstat_type q_stat;
   rau_item_type  q_item;
   rau_item_type  q_head;
   logic          q_push;
   logic          q_pop;

   // Accept and classify requests
   rau_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   // Buffer classified requests
   rau_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_item (q_item),
      .q_pop  (q_pop),
      .q_head (q_head),
      .q_stat (q_stat)
   );

   // Execute requests
   rau_back #(.WORD_BITS(WORD_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_res_num     (rsp_res_num),
      .rsp_res_den     (rsp_res_den),
      .rsp_whole_part  (rsp_whole_part),
      .rsp_status      (rsp_status),
      .rsp_cmp_less    (rsp_cmp_less),
      .rsp_cmp_equal   (rsp_cmp_equal),
      .rsp_cmp_greater (rsp_cmp_greater)
   );

endmodule

// ===== hw/rtl/rau_checker.sv =====
// Port-level checks of the rational arithmetic unit, bound to the top level.
module rau_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_mode,
   input logic signed [31:0] req_a_num,
   input logic [30:0]        req_a_den,
   input logic signed [31:0] req_b_num,
   input logic [30:0]        req_b_den,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_res_num,
   input logic [30:0]        rsp_res_den,
   input logic signed [31:0] rsp_whole_part,
   input logic [1:0]         rsp_status,
   input logic               rsp_cmp_less,
   input logic               rsp_cmp_equal,
   input logic               rsp_cmp_greater
);
   import rau_pkg::*;

   // No response right after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_num) &&
      $stable(rsp_status))
      else $error("stalled response changed");

   // Error responses carry the neutral fraction
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_res_num == 32'sd0 &&
      rsp_res_den == 31'd1 && rsp_whole_part == 32'sd0 &&
      !rsp_cmp_less && !rsp_cmp_equal && !rsp_cmp_greater)
      else $error("error response not neutral");

   // At most one compare flag
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_cmp_less, rsp_cmp_equal, rsp_cmp_greater}))
      else $error("several compare flags");

   // Denominator is never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_res_den != 31'd0)
      else $error("zero denominator in response");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
